/* rtl/sha_pkg.sv */
// SHA-256 hasher package: constants, types and round functions.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int BufDepth   = 16;
    localparam int BufAw      = 4;
    localparam int ChainDepth = 8;
    localparam int ChainAw    = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_CLOAD,
        ST_CWAIT,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } sha_state_t;

    // what follows a block once it has been compressed
    typedef enum logic [1:0] {
        NEXT_INPUT,
        NEXT_PAD,
        NEXT_DIGEST
    } next_step_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int r);
        return (v >> r) | (v << (32 - r));
    endfunction

endpackage

/* rtl/sha_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module sha_ram #(
    parameter int Width = 32,
    parameter int Depth = 16,
    parameter int Aw    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [Aw-1:0]    waddr,
    input  logic [Width-1:0] wdata,
    input  logic [Aw-1:0]    raddr,
    output logic [Width-1:0] rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/sha_core.sv */
// Compression rounds: working variables and 16-word schedule window.
`timescale 1ns / 1ps
module sha_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [2:0]  load_idx,
    input  logic [31:0] load_word,
    input  logic        round_en,
    input  logic [5:0]  round_t,
    input  logic [31:0] msg_word,
    input  logic [2:0]  var_idx,
    output logic [31:0] var_word
);
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] wt, s0, s1, t1, t2;

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wt = (round_t < 6'd16) ? msg_word : (w_reg[0] + s0 + w_reg[9] + s1);
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(round_t) + wt;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign var_word = v_reg[var_idx];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            v_reg[load_idx] <= load_word;
        end
        else if (round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            // advance the schedule window
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wt;
        end
    end
endmodule

/* rtl/sha256_byte_stream_hasher_top.sv */
// SHA-256 byte-stream hasher top level: buffer, chaining memory and sequencer.
//
//  channel | dir | signals                                  | item
//  in      | in  | in_valid, in_stall, data_byte, last_byte  | one message byte
//  out     | out | out_valid, out_stall, digest_word,        | one digest word
//          |     | word_index, last_word                     |
//
// Bytes are taken one per cycle while the input is not stalled and packed into
// 32-bit words of a 16-word block memory. A full block stalls the input while
// the working variables are loaded from the chaining memory, the 64 rounds run
// on the single round unit and the results are added back. A final byte adds
// padding at one byte per cycle (up to two blocks), then the first digest item
// is offered once its chain entry is read after the last add-back, and one per
// cycle after that while the output is not stalled.
// Reset clears control state and the length; chain values come from the
// initial constants through a valid flag. A stalled output holds its item.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_top
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    sha_state_t  state_reg, state_next;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [23:0] part_reg;
    logic        final_reg;
    logic        chain_ok_reg;   // chain memory holds real values
    logic [6:0]  cnt_reg;
    next_step_t  fill_flag_reg;  // what follows the pending block
    logic        pad_len_reg;
    logic        emit_v_reg;
    logic [2:0]  emit_i_reg;
    logic [31:0] emit_w_reg;
    logic [2:0]  ch_raddr_q;
    logic [31:0] var_word_q;

    logic        accept;
    logic        byte_wr;
    logic        buf_we;
    logic [3:0]  buf_waddr, buf_raddr;
    logic [31:0] buf_wdata, buf_rdata;
    logic        ch_we;
    logic [2:0]  ch_waddr, ch_raddr;
    logic [31:0] ch_wdata, ch_rdata, ch_val;
    logic        core_load, core_round;
    logic [31:0] var_word;
    logic [7:0]  pad_byte;
    logic        out_fire;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_fire = out_valid && !out_stall;
    assign ch_val   = chain_ok_reg ? ch_rdata : init_hash(ch_raddr_q);

    sha_ram #(.Width(32), .Depth(BufDepth), .Aw(BufAw)) u_buf (
        .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
        .raddr(buf_raddr), .rdata(buf_rdata));

    sha_ram #(.Width(32), .Depth(ChainDepth), .Aw(ChainAw)) u_chain (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata));

    sha_core u_core (
        .clk(clk), .load(core_load), .load_idx(cnt_reg[2:0] - 3'd1),
        .load_word(ch_val), .round_en(core_round), .round_t(cnt_reg[5:0]),
        .msg_word(buf_rdata), .var_idx(cnt_reg[2:0]), .var_word(var_word));

    // byte written this cycle: input, padding marker/zero, or length
    always_comb
    begin
        pad_byte = 8'h00;
        case (state_reg)
            ST_IDLE: pad_byte = data_byte;
            ST_PAD:  pad_byte = final_reg ? 8'h00 : 8'h80;
            ST_LEN:  pad_byte = bits_reg[63 - 8*fill_reg[2:0] -: 8];
            default: pad_byte = 8'h00;
        endcase
    end

    assign byte_wr   = accept || state_reg == ST_PAD || state_reg == ST_LEN;
    assign buf_we    = byte_wr && fill_reg[1:0] == 2'd3;
    assign buf_waddr = fill_reg[5:2];
    assign buf_wdata = {part_reg, pad_byte};

    // memory read addresses run ahead of use, as both memories register their read
    always_comb
    begin
        buf_raddr = 4'd0;
        ch_raddr  = 3'd0;
        if (state_reg == ST_ROUND)
        begin
            buf_raddr = cnt_reg[3:0] + 4'd1;
        end
        if (state_reg == ST_CLOAD || state_reg == ST_UPDATE)
        begin
            ch_raddr = cnt_reg[2:0];
        end
        else if (state_reg == ST_EMIT)
        begin
            // keep the word after the held item ready, or the one after that
            // when the held item leaves this cycle
            ch_raddr = emit_v_reg ? (emit_i_reg + 3'd1 + {2'd0, out_fire})
                                  : cnt_reg[2:0];
        end
    end

    assign core_load  = (state_reg == ST_CLOAD && cnt_reg != 7'd0)
                     || (state_reg == ST_CWAIT);
    assign core_round = (state_reg == ST_ROUND);

    // chain update: previous cycle read entry i, write back sum
    assign ch_we    = (state_reg == ST_UPDATE && cnt_reg != 7'd0);
    assign ch_waddr = cnt_reg[2:0] - 3'd1;
    assign ch_wdata = ch_val + var_word_q;

    always_ff @(posedge clk)
    begin
        ch_raddr_q <= ch_raddr;
        var_word_q <= var_word;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (fill_reg == 6'd63 || last_byte))
                begin
                    state_next = (fill_reg == 6'd63) ? ST_CLOAD : ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_CLOAD;
                end
                else if (fill_reg == 6'd55)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:    state_next = (fill_reg == 6'd63) ? ST_CLOAD : ST_LEN;
            ST_CLOAD:  state_next = (cnt_reg == 7'd7) ? ST_CWAIT : ST_CLOAD;
            ST_CWAIT:  state_next = ST_ROUND;
            ST_ROUND:  state_next = (cnt_reg == 7'd63) ? ST_UPDATE : ST_ROUND;
            ST_UPDATE:
            begin
                if (cnt_reg == 7'd8)
                begin
                    if (fill_flag_reg == NEXT_DIGEST)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (fill_flag_reg == NEXT_PAD)
                    begin
                        state_next = pad_len_reg ? ST_LEN : ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_fire && last_word)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid   = emit_v_reg;
    assign digest_word = emit_w_reg;
    assign word_index  = emit_i_reg;
    assign last_word   = (emit_i_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            bits_reg      <= 64'd0;
            part_reg      <= 24'd0;
            final_reg     <= 1'b0;
            chain_ok_reg  <= 1'b0;
            cnt_reg       <= 7'd0;
            fill_flag_reg <= NEXT_INPUT;
            pad_len_reg   <= 1'b0;
            emit_v_reg    <= 1'b0;
            emit_i_reg    <= 3'd0;
            emit_w_reg    <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (byte_wr)
            begin
                part_reg <= {part_reg[15:0], pad_byte};
                fill_reg <= fill_reg + 6'd1;
            end
            if (accept)
            begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (state_reg == ST_PAD)
            begin
                final_reg <= 1'b1;   // marker written, only zero padding follows before the length
            end
            // work out what follows the pending block
            if (state_next == ST_CLOAD && state_reg != ST_CLOAD)
            begin
                if (state_reg == ST_LEN)
                begin
                    fill_flag_reg <= NEXT_DIGEST;
                end
                else if (state_reg == ST_PAD)
                begin
                    fill_flag_reg <= NEXT_PAD;
                    pad_len_reg   <= 1'b0;
                end
                else
                begin
                    fill_flag_reg <= last_byte ? NEXT_PAD : NEXT_INPUT;
                    pad_len_reg   <= 1'b0;
                end
            end
            if (state_reg != state_next)
            begin
                cnt_reg <= 7'd0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
            if (state_reg == ST_UPDATE && cnt_reg == 7'd8)
            begin
                chain_ok_reg <= 1'b1;
            end
            // digest emit: read chain entry, hold it until taken
            if (state_reg == ST_EMIT)
            begin
                if (!emit_v_reg && cnt_reg == 7'd1)
                begin
                    emit_v_reg <= 1'b1;
                    emit_w_reg <= ch_rdata;
                    emit_i_reg <= 3'd0;
                end
                else if (out_fire)
                begin
                    if (last_word)
                    begin
                        emit_v_reg   <= 1'b0;
                        chain_ok_reg <= 1'b0;
                        fill_reg     <= 6'd0;
                        bits_reg     <= 64'd0;
                        final_reg    <= 1'b0;
                    end
                    else
                    begin
                        emit_i_reg <= emit_i_reg + 3'd1;
                        emit_w_reg <= ch_rdata;
                    end
                end
            end
        end
    end

    // a final byte that fills a block still needs a padding block
    // (handled by fill_flag NEXT_PAD with the marker pass in ST_PAD)

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> in_stall;
    endproperty
    assert property (p_stall_busy) else $error("input taken during rounds");

    property p_out_only_emit;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_EMIT);
    endproperty
    assert property (p_out_only_emit) else $error("digest outside emit");

    property p_idx_step;
        @(posedge clk) disable iff (!rst_n)
        (out_fire && !last_word) |=> (word_index == $past(word_index) + 3'd1);
    endproperty
    assert property (p_idx_step) else $error("word index skipped");
endmodule
